// ===== sv/rft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rft_pkg;
   localparam int SAMPLE_W          = 24;
   localparam int SPREAD_W          = 32;
   localparam int SLOPE_W           = 25;
   localparam int CNT_W             = 9;
   localparam int HISTORY_DEPTH_DEF = 32;
   localparam int TREND_WINDOW_DEF  = 8;
   localparam int TREND_MIN         = 3;
   localparam logic [SAMPLE_W-1:0] CEIL_RESET = 24'd10000000;
   localparam logic [27:0] CUTOFF_BIAS = 28'd100000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRACK,
      ST_PASS1,
      ST_DIV1,
      ST_PASS2,
      ST_DIV2,
      ST_TREND,
      ST_DIV3,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== sv/rft_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rft_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] rtt_sample;
   modport source (output valid, output rtt_sample, input ready);
   modport sink (input valid, input rtt_sample, output ready);
endinterface

interface rft_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [23:0]        min_rtt;
   logic [23:0]        max_rtt;
   logic [23:0]        mean_rtt;
   logic [31:0]        rtt_spread;
   logic signed [24:0] rtt_slope;
   logic [8:0]         kept_count;
   modport source (output valid, output accepted, output min_rtt, output max_rtt,
                   output mean_rtt, output rtt_spread, output rtt_slope,
                   output kept_count, input ready);
   modport sink (input valid, input accepted, input min_rtt, input max_rtt,
                 input mean_rtt, input rtt_spread, input rtt_slope,
                 input kept_count, output ready);
endinterface
`default_nettype wire

// ===== sv/rft_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rft_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/rft_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rft_div #(
   parameter int DW = 57
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DW-1:0]             dividend,
   input  wire logic [rft_pkg::CNT_W-1:0] divisor,
   output logic                           done,
   output logic      [DW-1:0]             quotient
);
   import rft_pkg::*;
   localparam int NW = $clog2(DW + 1);

   logic [DW-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] r_ff, r_in, d_ff, d_in;
   logic [NW-1:0]    n_ff, n_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W:0]   rs, diff;
   logic             ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         n_ff    <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   always_comb begin
      rs      = {r_ff, q_ff[DW-1]};
      diff    = rs - {1'b0, d_ff};
      ge      = rs >= {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         n_in    = NW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[DW-2:0], ge};
         r_in = ge ? diff[CNT_W-1:0] : rs[CNT_W-1:0];
         n_in = n_ff - 1'b1;
         if (n_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

// ===== sv/rtt_feature_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A rejected beat answers in the cycle after acceptance; an accepted beat answers
// once its serial divisions (at most three) and its passes over the single RAM
// read port (at most two over the history, one over the trend window) are done.
// The divider width is DW = 2*24 + log2(D) + 1 for history depth D.
// One beat at a time; ready only when idle, in the cycle after the result is taken.
// Synchronous reset clears the history (valid bits) and trackers and sets the ceiling to CEIL_RESET.
module rtt_feature_tracker_unit #(
   parameter int HISTORY_DEPTH = rft_pkg::HISTORY_DEPTH_DEF,
   parameter int TREND_WINDOW  = rft_pkg::TREND_WINDOW_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   rft_req_if.sink                           req_if,
   rft_rsp_if.source                         rsp_if,
   input  wire logic                         csr_we,
   input  wire logic [rft_pkg::SAMPLE_W-1:0] csr_wdata
);
   import rft_pkg::*;
   localparam int AW  = $clog2(HISTORY_DEPTH);
   localparam int DW  = 2 * SAMPLE_W + AW + 1;
   localparam int TSW = SAMPLE_W + $clog2(TREND_WINDOW) + 2;

   state_type              state_ff, state_in;
   logic [SAMPLE_W-1:0]    s_ff, s_in, ceil_ff, ceil_in;
   logic [AW-1:0]          wslot_ff, wslot_in, idx_ff, idx_in;
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic [SAMPLE_W-1:0]    min_ff, min_in, max_ff, max_in, mean_ff, mean_in;
   logic [SPREAD_W-1:0]    spread_ff, spread_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic                   acc_ff, acc_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, pairs_ff, pairs_in, n_ff, n_in;
   logic [DW-1:0]          sum_ff, sum_in;
   logic [1:0]             ph_ff, ph_in;
   logic [SAMPLE_W-1:0]    dd_ff, dd_in, prev_ff, prev_in;
   logic                   use_ff, use_in, neg_ff, neg_in;
   logic [2*SAMPLE_W-1:0]  sq_ff, sq_in;
   logic signed [TSW-1:0]  tsum_ff, tsum_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_raddr;
   logic [SAMPLE_W-1:0]    ram_rdata;
   logic                   div_start, div_done;
   logic [DW-1:0]          div_a, div_q;
   logic [CNT_W-1:0]       div_b;

   logic [27:0]            lim10, cutoff;
   logic [25:0]            lim3;
   logic [SAMPLE_W+8:0]    min_mix, max_mix;
   logic [SAMPLE_W-1:0]    min_drift, max_drift, x;
   logic [AW:0]            tslot;
   logic                   reject;
   logic [CNT_W-1:0]       n_next;
   logic [SLOPE_W-1:0]     q25;

   rft_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (wslot_ff),
      .wr_data    (req_if.rtt_sample),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   rft_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ceil_ff   <= CEIL_RESET;
         wslot_ff  <= '0;
         valid_ff  <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         mean_ff   <= '0;
         spread_ff <= '0;
         slope_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         ceil_ff   <= ceil_in;
         wslot_ff  <= wslot_in;
         valid_ff  <= valid_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         mean_ff   <= mean_in;
         spread_ff <= spread_in;
         slope_ff  <= slope_in;
      end
      s_ff     <= s_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      pairs_ff <= pairs_in;
      n_ff     <= n_in;
      sum_ff   <= sum_in;
      ph_ff    <= ph_in;
      dd_ff    <= dd_in;
      prev_ff  <= prev_in;
      use_ff   <= use_in;
      neg_ff   <= neg_in;
      sq_ff    <= sq_in;
      tsum_ff  <= tsum_in;
   end

   always_comb begin
      lim10   = {1'b0, mean_ff, 3'b0} + {3'b0, mean_ff, 1'b0};
      cutoff  = {2'b0, mean_ff, 2'b0} + {4'b0, mean_ff} + CUTOFF_BIAS;
      lim3    = {1'b0, mean_ff, 1'b0} + {2'b0, mean_ff};
      min_mix = {1'b0, min_ff, 8'b0} - {9'b0, min_ff} + {9'b0, s_ff};
      max_mix = {1'b0, max_ff, 8'b0} - {9'b0, max_ff} + {9'b0, s_ff};
      min_drift = min_mix[SAMPLE_W+7:8];
      max_drift = max_mix[SAMPLE_W+7:8];
      tslot   = {1'b0, wslot_ff} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(1) - {1'b0, idx_ff};
      if (tslot >= (AW+1)'(HISTORY_DEPTH)) begin
         tslot = tslot - (AW+1)'(HISTORY_DEPTH);
      end
      x       = valid_ff[ram_raddr] ? ram_rdata : '0;
      reject  = (req_if.rtt_sample == '0) || (req_if.rtt_sample > ceil_ff) ||
                ((mean_ff != '0) && ({4'b0, req_if.rtt_sample} > lim10));
      n_next  = (cnt_ff < CNT_W'(TREND_WINDOW)) ? cnt_ff : CNT_W'(TREND_WINDOW);
      q25     = div_q[SLOPE_W-1:0];

      state_in  = state_ff;
      ceil_in   = csr_we ? csr_wdata : ceil_ff;
      s_in      = s_ff;
      wslot_in  = wslot_ff;
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      mean_in   = mean_ff;
      spread_in = spread_ff;
      slope_in  = slope_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      pairs_in  = pairs_ff;
      n_in      = n_ff;
      sum_in    = sum_ff;
      ph_in     = ph_ff;
      dd_in     = dd_ff;
      prev_in   = prev_ff;
      use_in    = use_ff;
      neg_in    = neg_ff;
      sq_in     = sq_ff;
      tsum_in   = tsum_ff;
      ram_we    = 1'b0;
      ram_raddr = idx_ff;
      div_start = 1'b0;
      div_a     = sum_ff;
      div_b     = cnt_ff;
      req_if.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               s_in   = req_if.rtt_sample;
               acc_in = !reject;
               cnt_in = '0;
               if (reject) begin
                  state_in = ST_OUT;
               end else begin
                  ram_we = 1'b1;
                  valid_in[wslot_ff] = 1'b1;
                  wslot_in = (wslot_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_ff + 1'b1;
                  state_in = ST_TRACK;
               end
            end
         end
         ST_TRACK: begin
            if (min_ff == '0 || s_ff < min_ff) begin
               min_in = s_ff;
            end else begin
               min_in = (s_ff < min_drift) ? s_ff : min_drift;
            end
            if (s_ff > max_ff) begin
               max_in = s_ff;
            end else begin
               max_in = (s_ff > max_drift) ? s_ff : max_drift;
            end
            idx_in   = '0;
            ph_in    = '0;
            sum_in   = '0;
            state_in = ST_PASS1;
         end
         ST_PASS1: begin
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else begin
               ph_in = 2'd0;
               if (x != '0 && {4'b0, x} < cutoff) begin
                  sum_in = sum_ff + DW'(x);
                  cnt_in = cnt_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == AW'(HISTORY_DEPTH - 1)) begin
                  state_in = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (ph_ff == 2'd0) begin
               if (cnt_ff != '0) begin
                  div_start = 1'b1;
                  ph_in = 2'd1;
               end else begin
                  ph_in = 2'd2;
               end
            end else if (ph_ff == 2'd1) begin
               if (div_done) begin
                  mean_in = div_q[SAMPLE_W-1:0];
                  ph_in   = 2'd2;
               end
            end else begin
               idx_in = '0;
               ph_in  = '0;
               sum_in = '0;
               use_in = 1'b0;
               if (cnt_ff > CNT_W'(1) && mean_ff != '0) begin
                  state_in = ST_PASS2;
               end else begin
                  state_in = ST_DIV2;
                  ph_in    = 2'd3;
               end
            end
         end
         ST_PASS2: begin
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin
                  use_in = (x != '0) && ({2'b0, x} < lim3);
                  dd_in  = (x > mean_ff) ? x - mean_ff : mean_ff - x;
                  ph_in  = 2'd2;
               end
               2'd2: begin
                  sq_in = dd_ff * dd_ff;
                  ph_in = 2'd3;
               end
               default: begin
                  if (use_ff) begin
                     sum_in = sum_ff + DW'(sq_ff);
                  end
                  ph_in  = 2'd0;
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == AW'(HISTORY_DEPTH - 1)) begin
                     state_in = ST_DIV2;
                  end
               end
            endcase
         end
         ST_DIV2: begin
            if (ph_ff == 2'd0) begin
               div_start = 1'b1;
               ph_in = 2'd1;
            end else if (ph_ff == 2'd1) begin
               if (div_done) begin
                  spread_in = div_q[SPREAD_W-1:0];
                  ph_in = 2'd3;
               end
            end else begin
               idx_in   = '0;
               ph_in    = '0;
               tsum_in  = '0;
               pairs_in = '0;
               prev_in  = '0;
               n_in     = n_next;
               state_in = (n_next >= CNT_W'(TREND_MIN)) ? ST_TREND : ST_OUT;
            end
         end
         ST_TREND: begin
            ram_raddr = tslot[AW-1:0];
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else begin
               ph_in = 2'd0;
               if (!(x == '0 || (mean_ff != '0 && {2'b0, x} > lim3))) begin
                  if (prev_ff != '0) begin
                     tsum_in  = tsum_ff + TSW'(signed'({1'b0, prev_ff})) -
                                TSW'(signed'({1'b0, x}));
                     pairs_in = pairs_ff + 1'b1;
                  end
                  prev_in = x;
               end
               idx_in = idx_ff + 1'b1;
               if ({{(CNT_W-AW){1'b0}}, idx_ff} == n_ff - 1'b1) begin
                  state_in = ST_DIV3;
               end
            end
         end
         ST_DIV3: begin
            div_a = DW'(tsum_ff < 0 ? -tsum_ff : tsum_ff);
            div_b = pairs_ff;
            if (ph_ff == 2'd0) begin
               neg_in = tsum_ff < 0;
               if (pairs_ff != '0) begin
                  div_start = 1'b1;
                  ph_in = 2'd1;
               end else begin
                  state_in = ST_OUT;
               end
            end else if (div_done) begin
               slope_in = neg_ff ? -signed'(q25) : signed'(q25);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_if.valid       = (state_ff == ST_OUT);
   assign rsp_if.accepted    = acc_ff;
   assign rsp_if.min_rtt     = min_ff;
   assign rsp_if.max_rtt     = max_ff;
   assign rsp_if.mean_rtt    = mean_ff;
   assign rsp_if.rtt_spread  = spread_ff;
   assign rsp_if.rtt_slope   = slope_ff;
   assign rsp_if.kept_count  = acc_ff ? cnt_ff : '0;

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("ready while result pending");
   a_rej_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.accepted |-> rsp_if.kept_count == '0)
      else $error("rejected beat with nonzero count");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.kept_count <= CNT_W'(HISTORY_DEPTH))
      else $error("count above depth");
   a_rej_fast: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && reject |=> rsp_if.valid)
      else $error("reject not answered next cycle");
endmodule
`default_nettype wire
